// ===== src/cce_pkg.sv =====
// ----------------------------------------------------------------------------
// cce_pkg
// shared constants for the cyclic code encoder and syndrome checker
// ----------------------------------------------------------------------------
package cce_pkg;

	localparam int MSG_BITS_DEF = 32;
	localparam int GEN_BITS_DEF = 17;

	localparam int WORD_W = 48;
	localparam int SYN_W  = 16;
	localparam int MW_W   = 6;

	localparam int GEN_RESET = 69665;
	localparam int MW_RESET  = 16;

	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_GENERATOR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MSG_WIDTH = 1'd1;

endpackage

// ===== src/cyclic_code_encode_check.sv =====
// ----------------------------------------------------------------------------
// cyclic_code_encode_check
// systematic cyclic encoder with syndrome check over one serial divider
// ----------------------------------------------------------------------------
// Takes a message and an error pattern, builds the systematic codeword
// (message shifted up r places, remainder mod g(x) in the low bits), adds
// the error bits below the codeword length and reports the syndrome of the
// received word with detected / undetected flags. r is the degree of the
// generator register. One GEN_BITS-1 bit division shift register does all the
// work, one bit per cycle: MSG_BITS steps over the message, r steps of
// appended zeros, a build step for codeword and received word, then 48 steps
// over the received word. The input is stalled from input transfer until
// the result is handed to the output register; a message out of range for
// the width register skips the division and goes to the done state instead.
// A result waiting on a stalled output does not block the next input
// transfer, only the end of the next item.
// ----------------------------------------------------------------------------
module cyclic_code_encode_check
	import cce_pkg::*;
#(
	parameter int MSG_BITS = MSG_BITS_DEF,
	parameter int GEN_BITS = GEN_BITS_DEF,
	localparam int CFG_W = (GEN_BITS > MW_W) ? GEN_BITS : MW_W
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [MSG_BITS-1:0]  message,
	input  logic [WORD_W-1:0]    error_pattern,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [WORD_W-1:0]    codeword,
	output logic [WORD_W-1:0]    received,
	output logic [SYN_W-1:0]     syndrome,
	output logic                 detected,
	output logic                 undetected,
	output logic                 range_error
);

	localparam int RW    = GEN_BITS - 1;
	localparam int R_W   = $clog2(GEN_BITS);
	localparam int MAXC  = (MSG_BITS > WORD_W) ? MSG_BITS : WORD_W;
	localparam int CNT_W = $clog2(MAXC + 1);
	localparam int N_W   = CNT_W + 1;
	localparam int SH_W  = MSG_BITS + RW;
	localparam int WIDE_W = (SH_W > WORD_W) ? SH_W : WORD_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MSG  = 3'd1;
	localparam logic [2:0] ST_ZERO = 3'd2;
	localparam logic [2:0] ST_BUILD = 3'd3;
	localparam logic [2:0] ST_RECV = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]          state_q;
	logic [GEN_BITS-1:0] generator_q;
	logic [MW_W-1:0]     mw_q;

	logic [GEN_BITS-1:0] g_eff_q;
	logic [R_W-1:0]      r_q;
	logic [RW-1:0]       rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    mlen_q;
	logic [MSG_BITS-1:0] msg_q;
	logic [MSG_BITS-1:0] msg_sh_q;
	logic [WORD_W-1:0]   err_q;
	logic [WORD_W-1:0]   code_q;
	logic [WORD_W-1:0]   recv_q;
	logic [WORD_W-1:0]   recv_sh_q;
	logic                err_nz_q;
	logic                range_q;

	logic                out_valid_q;
	logic [WORD_W-1:0]   codeword_q;
	logic [WORD_W-1:0]   received_q;
	logic [SYN_W-1:0]    syndrome_q;
	logic                detected_q;
	logic                undetected_q;
	logic                range_error_q;

	logic                in_xfer;
	logic                cfg_xfer;
	logic                out_free;
	logic                range_c;
	logic [R_W-1:0]      r_c;
	logic                div_bit;
	logic [GEN_BITS-1:0] div_in;
	logic [GEN_BITS-1:0] div_x;
	logic [RW-1:0]       rem_d;
	logic [WIDE_W-1:0]   msg_wide;
	logic [WIDE_W-1:0]   msg_shl;
	logic [WORD_W-1:0]   code_c;
	logic [N_W-1:0]      n_c;
	logic [WORD_W-1:0]   nmask_c;
	logic [WORD_W-1:0]   emask_c;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || !out_stall;
	assign range_c   = ((message >> mw_q) != '0);

	// degree of the generator, zero generator counts as degree zero
	always_comb begin
		r_c = '0;
		for (int i = 1; i < GEN_BITS; i++) begin
			if (generator_q[i]) begin
				r_c = R_W'(i);
			end
		end
	end

	// one step of the division register
	always_comb begin
		unique case (state_q)
			ST_MSG:  div_bit = msg_sh_q[MSG_BITS-1];
			ST_RECV: div_bit = recv_sh_q[WORD_W-1];
			default: div_bit = 1'b0;
		endcase
		div_in = {rem_q, div_bit};
		div_x  = div_in[r_q] ? (div_in ^ g_eff_q) : div_in;
		rem_d  = div_x[RW-1:0];
	end

	// codeword and masked error
	always_comb begin
		msg_wide = WIDE_W'(msg_q);
		msg_shl  = msg_wide << r_q;
		code_c   = WORD_W'(msg_shl) | WORD_W'(rem_q);
		n_c      = N_W'(mlen_q) + N_W'(r_q);
		for (int i = 0; i < WORD_W; i++) begin
			nmask_c[i] = (N_W'(i) < n_c) || (i >= (1 << N_W) - 1);
		end
		emask_c = err_q & nmask_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			generator_q <= GEN_BITS'(GEN_RESET);
			mw_q        <= MW_W'(MW_RESET);
		end else if (cfg_xfer) begin
			unique case (cfg_index)
				REG_GENERATOR: generator_q <= cfg_data[GEN_BITS-1:0];
				REG_MSG_WIDTH: mw_q        <= cfg_data[MW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= range_c ? ST_DONE : ST_MSG;
					end
				end
				ST_MSG: begin
					if (cnt_q == CNT_W'(1)) begin
						state_q <= (r_q == '0) ? ST_BUILD : ST_ZERO;
					end
				end
				ST_ZERO: begin
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_BUILD;
					end
				end
				ST_BUILD: state_q <= ST_RECV;
				ST_RECV: begin
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					g_eff_q   <= (generator_q == '0) ? GEN_BITS'(1) : generator_q;
					r_q       <= r_c;
					rem_q     <= '0;
					cnt_q     <= CNT_W'(MSG_BITS);
					mlen_q    <= '0;
					msg_q     <= message;
					msg_sh_q  <= message;
					err_q     <= error_pattern;
					code_q    <= '0;
					recv_q    <= '0;
					err_nz_q  <= 1'b0;
					range_q   <= range_c;
				end
			end
			ST_MSG: begin
				rem_q    <= rem_d;
				msg_sh_q <= msg_sh_q << 1;
				if (msg_sh_q[MSG_BITS-1] && (mlen_q == '0)) begin
					mlen_q <= cnt_q;
				end
				cnt_q <= (cnt_q == CNT_W'(1)) ? CNT_W'(r_q) : cnt_q - CNT_W'(1);
			end
			ST_ZERO: begin
				rem_q <= rem_d;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_BUILD: begin
				code_q    <= code_c;
				recv_q    <= code_c ^ emask_c;
				recv_sh_q <= code_c ^ emask_c;
				err_nz_q  <= (emask_c != '0);
				rem_q     <= '0;
				cnt_q     <= CNT_W'(WORD_W);
			end
			ST_RECV: begin
				rem_q     <= rem_d;
				recv_sh_q <= recv_sh_q << 1;
				cnt_q     <= cnt_q - CNT_W'(1);
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			codeword_q    <= code_q;
			received_q    <= recv_q;
			syndrome_q    <= SYN_W'(rem_q);
			detected_q    <= (rem_q != '0);
			undetected_q  <= (rem_q == '0) && err_nz_q;
			range_error_q <= range_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign codeword    = codeword_q;
	assign received    = received_q;
	assign syndrome    = syndrome_q;
	assign detected    = detected_q;
	assign undetected  = undetected_q;
	assign range_error = range_error_q;

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(detected && undetected))
		else $error("detected and undetected both set");

	a_range_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> (codeword == '0) && (received == '0)
			&& (syndrome == '0) && !detected && !undetected)
		else $error("range result carries data");

	a_xfer_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_MSG) || (state_q == ST_DONE))
		else $error("input transfer did not start an item");

	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MSG) || (state_q == ST_ZERO) || (state_q == ST_RECV)
			|-> (cnt_q != '0))
		else $error("bit counter ran out in a division phase");

endmodule
